@@ src/hsl_pkg.sv @@
// Package for the HSL to RGB converter: hue turn constants, reciprocal
// constants for the hue wrap, and the channel segment code. No dependencies.
package hsl_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // hue input and turn geometry, 1/64 degree per unit
  localparam int HUE_W          = 24;
  localparam int TURN           = 23040;
  localparam int SIXTH_TURN     = TURN / 6;
  localparam int THIRD_TURN     = TURN / 3;
  localparam int HALF_TURN      = TURN / 2;
  localparam int TWO_THIRD_TURN = 2 * TURN / 3;

  // hue is biased to unsigned by flipping the sign bit (adds 2^23); this
  // offset brings the biased value back to the same residue mod TURN
  localparam int HUE_OFS = TURN - ((1 << (HUE_W - 1)) % TURN);

  localparam int HV_W = HUE_W + 1;   // biased hue plus offset
  localparam int HQ_W = 10;          // quotient of biased hue by TURN
  localparam int HR_W = 16;          // remainder before final correction, < 2*TURN
  localparam int HT_W = 15;          // wrapped hue, < TURN
  localparam int HF_W = 12;          // ramp position, <= SIXTH_TURN

  // floor reciprocal: estimate is exact or one low for any HV_W-bit value
  localparam int          HUE_RECIP_SH = 39;
  localparam longint      HUE_RECIP    = (64'd1 << HUE_RECIP_SH) / TURN;
  localparam int          HP_W         = 2 * HV_W;

  typedef enum logic [1:0] {
    SEG_RAMP,
    SEG_Q,
    SEG_P
  } seg_t;

endpackage

@@ src/hsl_to_rgb_convert.sv @@
// HSL to RGB converter, top level: eleven-stage pipeline with per-stage
// valid bits and local backpressure. Depends on hsl_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one HSL color per beat:
//   in_hue_q6 (signed degrees * 64, any value, wrapped mod 360 degrees),
//   in_saturation and in_lightness (Q1.FRAC_BITS, codes above 1.0 clamp).
//   Output channel out_valid/out_ready carries one RGB color per beat:
//   out_red, out_green, out_blue in Q1.FRAC_BITS, each within [0, 1.0].
//   Throughput: one beat per cycle while out_ready stays high.
//   Each stage loads when it is empty or the stage after it loads, so
//   bubbles are squeezed out when the receiver stalls: the pipe keeps
//   taking beats until all eleven stages hold data, then drops in_ready.
//   Nothing is lost or repeated across a stall.
//   Reset (rst_n low, synchronous) empties every stage; payload registers
//   are not cleared. Zero saturation needs no special path: q = p = l.
//   Stage plan: 0 input clamp/hue bias, 1 hue reciprocal multiply and
//   l*s, 2 hue remainder and q, 3 hue correction and q clamp, 4 p and
//   per-channel hue, 5 segment decode, 6 (q-p)*ramp, 7 bias and >>8,
//   8 reciprocal multiply by 1/15, 9 quotient fix, 10 channel select.
module hsl_to_rgb_convert #(
  parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [hsl_pkg::HUE_W-1:0]    in_hue_q6,
  input  logic        [FRAC_BITS:0]           in_saturation,
  input  logic        [FRAC_BITS:0]           in_lightness,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [FRAC_BITS:0]           out_red,
  output logic        [FRAC_BITS:0]           out_green,
  output logic        [FRAC_BITS:0]           out_blue
);
  import hsl_pkg::*;

  localparam int W     = FRAC_BITS + 1;
  localparam int NSTG  = 11;
  localparam int XW    = W + HF_W;          // (q-p) * ramp position
  localparam int YW    = XW - 8 + 1;        // (x + 1920) >> 8
  localparam int PW    = 2 * YW;
  localparam longint DIV15_RECIP = (64'd1 << YW) / 15;
  localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  // stage registers
  logic [HV_W-1:0]   v0_r;
  logic [W-1:0]      s0_r, l0_r;
  logic [HQ_W-1:0]   qe1_r;
  logic [HV_W-1:0]   v1_r;
  logic [2*W-1:0]    ls1_r;
  logic [W-1:0]      s1_r, l1_r;
  logic [HR_W-1:0]   r2_r;
  logic [W:0]        q2_r;
  logic [W-1:0]      l2_r;
  logic [HT_W-1:0]   h3_r;
  logic [W-1:0]      q3_r, l3_r;
  logic [W-1:0]      p4_r, q4_r;
  logic [HT_W-1:0]   t4_r [3];
  logic [W-1:0]      d5_r, p5_r, q5_r;
  seg_t              sel5_r [3];
  logic [HF_W-1:0]   f5_r [3];
  logic [W-1:0]      p6_r, q6_r;
  seg_t              sel6_r [3];
  logic [XW-1:0]     x6_r [3];
  logic [W-1:0]      p7_r, q7_r;
  seg_t              sel7_r [3];
  logic [YW-1:0]     y7_r [3];
  logic [W-1:0]      p8_r, q8_r;
  seg_t              sel8_r [3];
  logic [YW-1:0]     y8_r [3];
  logic [PW-1:0]     yp8_r [3];
  logic [W-1:0]      p9_r, q9_r;
  seg_t              sel9_r [3];
  logic [W-1:0]      rmp9_r [3];
  logic [W-1:0]      ch10_r [3];

  // combinational next values
  logic [HV_W-1:0]   v0_nxt;
  logic [W-1:0]      s0_nxt, l0_nxt;
  logic [HP_W-1:0]   hp1;
  logic [HV_W-1:0]   rfull2;
  logic [2*W-1:0]    mr_full2;
  logic [W:0]        mr2, q2_nxt;
  logic [HT_W-1:0]   h3_nxt;
  logic [W-1:0]      q3_nxt;
  logic [W:0]        l2x4;
  logic [W-1:0]      p4_nxt;
  logic [HR_W-1:0]   tr4;
  logic [HT_W-1:0]   t4_nxt [3];
  seg_t              sel5_nxt [3];
  logic [HF_W-1:0]   f5_nxt [3];
  logic [XW:0]       xb7 [3];
  logic [YW-1:0]     qe9 [3];
  logic [YW-1:0]     rem9 [3];
  logic [W-1:0]      rmp9_nxt [3];
  logic [W-1:0]      ch10_nxt [3];

  // a stage loads when it is empty or its successor loads
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // stage 0: bias hue to unsigned, clamp s and l to 1.0
  always_comb begin
    v0_nxt = {1'b0, ~in_hue_q6[HUE_W-1], in_hue_q6[HUE_W-2:0]} + HV_W'(HUE_OFS);
    s0_nxt = (in_saturation > ONE) ? ONE : in_saturation;
    l0_nxt = (in_lightness > ONE) ? ONE : in_lightness;
  end

  // stage 1: quotient estimate by TURN, l*s
  assign hp1 = HP_W'(v0_r) * HP_W'(HUE_RECIP);

  // stage 2: remainder (below 2*TURN), q before clamp
  always_comb begin
    rfull2   = v1_r - HV_W'(qe1_r) * HV_W'(TURN);
    mr_full2 = ls1_r + (2*W)'(HALF);
    mr2      = (W+1)'(mr_full2 >> FRAC_BITS);
    if (l1_r < HALF) begin
      q2_nxt = {1'b0, l1_r} + mr2;
    end else begin
      q2_nxt = {1'b0, l1_r} + {1'b0, s1_r} - mr2;
    end
  end

  // stage 3: final hue correction, clamp q
  always_comb begin
    h3_nxt = (r2_r >= HR_W'(TURN)) ? HT_W'(r2_r - HR_W'(TURN)) : HT_W'(r2_r);
    q3_nxt = (q2_r > {1'b0, ONE}) ? ONE : q2_r[W-1:0];
  end

  // stage 4: p = max(2l - q, 0); hue shifted by a third turn each way
  always_comb begin
    l2x4   = {l3_r, 1'b0};
    p4_nxt = (l2x4 >= {1'b0, q3_r}) ? W'(l2x4 - {1'b0, q3_r}) : '0;
    tr4    = HR_W'(h3_r) + HR_W'(THIRD_TURN);
    t4_nxt[0] = (tr4 >= HR_W'(TURN)) ? HT_W'(tr4 - HR_W'(TURN)) : HT_W'(tr4);
    t4_nxt[1] = h3_r;
    t4_nxt[2] = (h3_r >= HT_W'(THIRD_TURN)) ? HT_W'(h3_r - HT_W'(THIRD_TURN))
                                           : HT_W'(h3_r + HT_W'(TWO_THIRD_TURN));
  end

  // stage 5: segment decode per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (t4_r[c] < HT_W'(SIXTH_TURN)) begin
        sel5_nxt[c] = SEG_RAMP;
        f5_nxt[c]   = HF_W'(t4_r[c]);
      end else if (t4_r[c] < HT_W'(HALF_TURN)) begin
        sel5_nxt[c] = SEG_Q;
        f5_nxt[c]   = '0;
      end else if (t4_r[c] < HT_W'(TWO_THIRD_TURN)) begin
        sel5_nxt[c] = SEG_RAMP;
        f5_nxt[c]   = HF_W'(HT_W'(TWO_THIRD_TURN) - t4_r[c]);
      end else begin
        sel5_nxt[c] = SEG_P;
        f5_nxt[c]   = '0;
      end
    end
  end

  // stages 7..9: round((q-p)*f / 3840) as floor(floor((x+1920)/256)/15)
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      xb7[c]      = (XW+1)'(x6_r[c]) + (XW+1)'(SIXTH_TURN / 2);
      qe9[c]      = YW'(yp8_r[c] >> YW);
      rem9[c]     = y8_r[c] - ((qe9[c] << 4) - qe9[c]);
      rmp9_nxt[c] = (rem9[c] >= YW'(15)) ? W'(qe9[c] + YW'(1)) : W'(qe9[c]);
    end
  end

  // stage 10: pick ramp, q or p
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (sel9_r[c])
        SEG_RAMP: ch10_nxt[c] = p9_r + rmp9_r[c];
        SEG_Q:    ch10_nxt[c] = q9_r;
        default:  ch10_nxt[c] = p9_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      v0_r <= v0_nxt;
      s0_r <= s0_nxt;
      l0_r <= l0_nxt;
    end
    if (en[1]) begin
      qe1_r <= hp1[HUE_RECIP_SH +: HQ_W];
      v1_r  <= v0_r;
      ls1_r <= (2*W)'(l0_r) * (2*W)'(s0_r);
      s1_r  <= s0_r;
      l1_r  <= l0_r;
    end
    if (en[2]) begin
      r2_r <= rfull2[HR_W-1:0];
      q2_r <= q2_nxt;
      l2_r <= l1_r;
    end
    if (en[3]) begin
      h3_r <= h3_nxt;
      q3_r <= q3_nxt;
      l3_r <= l2_r;
    end
    if (en[4]) begin
      p4_r <= p4_nxt;
      q4_r <= q3_r;
      for (int c = 0; c < 3; c++) t4_r[c] <= t4_nxt[c];
    end
    if (en[5]) begin
      d5_r <= (q4_r > p4_r) ? W'(q4_r - p4_r) : '0;
      p5_r <= p4_r;
      q5_r <= q4_r;
      for (int c = 0; c < 3; c++) begin
        sel5_r[c] <= sel5_nxt[c];
        f5_r[c]   <= f5_nxt[c];
      end
    end
    if (en[6]) begin
      p6_r <= p5_r;
      q6_r <= q5_r;
      for (int c = 0; c < 3; c++) begin
        sel6_r[c] <= sel5_r[c];
        x6_r[c]   <= XW'(d5_r) * XW'(f5_r[c]);
      end
    end
    if (en[7]) begin
      p7_r <= p6_r;
      q7_r <= q6_r;
      for (int c = 0; c < 3; c++) begin
        sel7_r[c] <= sel6_r[c];
        y7_r[c]   <= YW'(xb7[c] >> 8);
      end
    end
    if (en[8]) begin
      p8_r <= p7_r;
      q8_r <= q7_r;
      for (int c = 0; c < 3; c++) begin
        sel8_r[c] <= sel7_r[c];
        y8_r[c]   <= y7_r[c];
        yp8_r[c]  <= PW'(y7_r[c]) * PW'(DIV15_RECIP);
      end
    end
    if (en[9]) begin
      p9_r <= p8_r;
      q9_r <= q8_r;
      for (int c = 0; c < 3; c++) begin
        sel9_r[c] <= sel8_r[c];
        rmp9_r[c] <= rmp9_nxt[c];
      end
    end
    if (en[10]) begin
      for (int c = 0; c < 3; c++) ch10_r[c] <= ch10_nxt[c];
    end
  end

  assign out_red   = ch10_r[0];
  assign out_green = ch10_r[1];
  assign out_blue  = ch10_r[2];

endmodule
